### src/frd_pkg.sv
`timescale 1ns / 1ps

package frd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int STATUS_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam int HDR_CNT_W = 3;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = 3'd7;
    localparam logic [HDR_CNT_W-1:0] HDR_VER  = 3'd0;
    localparam logic [HDR_CNT_W-1:0] HDR_TYPE = 3'd1;
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI = 3'd4;
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO = 3'd5;
    localparam logic [HDR_CNT_W-1:0] HDR_PAD  = 3'd6;

    localparam int EB_CNT_W = 4;
    localparam int EB_KEEP  = 5;
    localparam int EB_IDX_W = 3;
    localparam logic [EB_IDX_W-1:0] EB_STATUS_IDX = 3'd4;
    localparam logic [LEN_W-1:0] END_BODY_LEN = 16'd8;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ROUTE_HEADER  = 3'd0,
        ROUTE_STDOUT  = 3'd1,
        ROUTE_STDERR  = 3'd2,
        ROUTE_END     = 3'd3,
        ROUTE_OTHER   = 3'd4,
        ROUTE_PADDING = 3'd5,
        ROUTE_IGNORED = 3'd6
    } t_route;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_VERSION    = 3'd1,
        ERR_TYPE       = 3'd2,
        ERR_END_SIZE   = 3'd3,
        ERR_END_STATUS = 3'd4
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_VERSION = 3'd0,
        CFG_MAX_RECORD_TYPE  = 3'd1,
        CFG_STDOUT_TYPE      = 3'd2,
        CFG_STDERR_TYPE      = 3'd3,
        CFG_END_REQUEST_TYPE = 3'd4,
        CFG_COMPLETE_STATUS  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_version;
        logic [BYTE_W-1:0] max_record_type;
        logic [BYTE_W-1:0] stdout_type_code;
        logic [BYTE_W-1:0] stderr_type_code;
        logic [BYTE_W-1:0] end_request_type_code;
        logic [BYTE_W-1:0] complete_status_code;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        t_route              route;
        logic [BYTE_W-1:0]   record_type;
        logic [LEN_W-1:0]    content_remaining;
        logic                record_done;
        logic [STATUS_W-1:0] exit_status;
        logic                exit_valid;
        t_err                error_code;
    } t_res;

    function automatic t_route content_route(input logic [BYTE_W-1:0] rec_type,
                                             input t_cfg cfg);
        t_route rt;
        if (rec_type == cfg.stdout_type_code) begin
            rt = ROUTE_STDOUT;
        end else if (rec_type == cfg.stderr_type_code) begin
            rt = ROUTE_STDERR;
        end else if (rec_type == cfg.end_request_type_code) begin
            rt = ROUTE_END;
        end else begin
            rt = ROUTE_OTHER;
        end
        return rt;
    endfunction

endpackage

### src/frd_byte_if.sv
`timescale 1ns / 1ps

interface frd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

### src/frd_rec_if.sv
`timescale 1ns / 1ps

interface frd_rec_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [2:0]  route;
    logic [7:0]  record_type;
    logic [15:0] content_remaining;
    logic        record_done;
    logic [31:0] exit_status;
    logic        exit_valid;
    logic [2:0]  error_code;

    modport source (
        output valid, output payload_byte, output route, output record_type,
        output content_remaining, output record_done, output exit_status,
        output exit_valid, output error_code, input ready
    );
    modport sink (
        input valid, input payload_byte, input route, input record_type,
        input content_remaining, input record_done, input exit_status,
        input exit_valid, input error_code, output ready
    );
endinterface

### src/frd_parser.sv
`timescale 1ns / 1ps

module frd_parser
    import frd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_space,
    output logic              o_push,
    output t_res              o_res
);

    logic [HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic                 r_in_hdr, n_in_hdr;
    logic [BYTE_W-1:0]    r_ver, n_ver;
    logic [BYTE_W-1:0]    r_cur_type, n_cur_type;
    logic [LEN_W-1:0]     r_content, n_content;
    logic [BYTE_W-1:0]    r_pad, n_pad;
    logic [BYTE_W-1:0]    r_eb [EB_KEEP];
    logic [BYTE_W-1:0]    n_eb [EB_KEEP];
    logic [EB_CNT_W-1:0]  r_eb_cnt, n_eb_cnt;
    t_err                 r_err, n_err;

    logic                 accept;
    logic [EB_IDX_W-1:0]  eb_idx;
    t_route               hdr_route;
    t_route               cur_route;
    t_res                 res;

    assign accept = i_valid && i_space;
    assign o_push = accept;
    assign o_res  = res;
    assign eb_idx = r_eb_cnt[EB_IDX_W-1:0];
    assign hdr_route = content_route(r_cur_type, i_cfg);
    assign cur_route = content_route(r_cur_type, i_cfg);

    always_comb begin
        n_hdr_cnt  = r_hdr_cnt;
        n_in_hdr   = r_in_hdr;
        n_ver      = r_ver;
        n_cur_type = r_cur_type;
        n_content  = r_content;
        n_pad      = r_pad;
        n_eb       = r_eb;
        n_eb_cnt   = r_eb_cnt;
        n_err      = r_err;

        res.payload_byte      = i_byte;
        res.route             = ROUTE_IGNORED;
        res.record_type       = '0;
        res.content_remaining = '0;
        res.record_done       = 1'b0;
        res.exit_status       = '0;
        res.exit_valid        = 1'b0;

        if (r_err != ERR_NONE) begin
            res.route = ROUTE_IGNORED;
        end else if (r_in_hdr) begin
            res.route = ROUTE_HEADER;
            case (r_hdr_cnt)
                HDR_VER:    n_ver = i_byte;
                HDR_TYPE:   n_cur_type = i_byte;
                HDR_LEN_HI: n_content[LEN_W-1:BYTE_W] = i_byte;
                HDR_LEN_LO: n_content[BYTE_W-1:0] = i_byte;
                HDR_PAD:    n_pad = i_byte;
                default: ;
            endcase
            if (r_hdr_cnt != HDR_LAST) begin
                n_hdr_cnt = r_hdr_cnt + 1'b1;
                if (r_hdr_cnt == HDR_VER) begin
                    res.record_type = '0;
                end else if (r_hdr_cnt == HDR_TYPE) begin
                    res.record_type = i_byte;
                end else begin
                    res.record_type = r_cur_type;
                end
            end else begin
                n_hdr_cnt = '0;
                n_eb_cnt  = '0;
                res.record_type       = r_cur_type;
                res.content_remaining = r_content;
                if (r_ver != i_cfg.expected_version) begin
                    n_err = ERR_VERSION;
                end else if (r_cur_type > i_cfg.max_record_type) begin
                    n_err = ERR_TYPE;
                end else if (hdr_route == ROUTE_END && r_content != END_BODY_LEN) begin
                    n_err = ERR_END_SIZE;
                end
                if (n_err == ERR_NONE) begin
                    if (r_content == '0 && r_pad == '0) begin
                        res.record_done = 1'b1;
                    end else begin
                        n_in_hdr = 1'b0;
                    end
                end
            end
        end else if (r_content != '0) begin
            n_content = r_content - 1'b1;
            res.route             = cur_route;
            res.record_type       = r_cur_type;
            res.content_remaining = n_content;
            if (cur_route == ROUTE_END) begin
                if (eb_idx < EB_IDX_W'(EB_KEEP)) begin
                    n_eb[eb_idx] = i_byte;
                end
                n_eb_cnt = r_eb_cnt + 1'b1;
                if (n_content == '0) begin
                    n_eb_cnt = '0;
                    if (n_eb[EB_STATUS_IDX] != i_cfg.complete_status_code) begin
                        n_err = ERR_END_STATUS;
                    end else begin
                        res.exit_status = {n_eb[0], n_eb[1], n_eb[2], n_eb[3]};
                        res.exit_valid  = 1'b1;
                    end
                end
            end
            if (n_err == ERR_NONE && n_content == '0 && r_pad == '0) begin
                res.record_done = 1'b1;
                n_in_hdr = 1'b1;
            end
        end else begin
            res.route       = ROUTE_PADDING;
            res.record_type = r_cur_type;
            if (r_pad != '0) begin
                n_pad = r_pad - 1'b1;
            end
            if (n_pad == '0) begin
                res.record_done = 1'b1;
                n_in_hdr = 1'b1;
            end
        end

        res.error_code = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt  <= '0;
            r_in_hdr   <= 1'b1;
            r_cur_type <= '0;
            r_content  <= '0;
            r_pad      <= '0;
            r_eb_cnt   <= '0;
            r_err      <= ERR_NONE;
        end else if (accept) begin
            r_hdr_cnt  <= n_hdr_cnt;
            r_in_hdr   <= n_in_hdr;
            r_cur_type <= n_cur_type;
            r_content  <= n_content;
            r_pad      <= n_pad;
            r_eb_cnt   <= n_eb_cnt;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ver <= n_ver;
            r_eb  <= n_eb;
        end
    end

endmodule

### src/frd_queue.sv
`timescale 1ns / 1ps

module frd_queue
    import frd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_space,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    t_res            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    logic [Q_CW-1:0] r_cnt, n_cnt;
    logic            pop;

    assign o_valid = (r_cnt != '0);
    assign o_space = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_res   = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

### src/fastcgi_record_deframer.sv
// Record deframer for the server-to-web direction of a FastCGI byte stream.
// Bytes enter on i_in, one per transaction, and every byte leaves as exactly
// one transaction on o_out carrying the byte, its route, the record type,
// the content bytes still to come, the end-of-record flag, the exit status
// of a completed end-request body and the sticky error code.
// A parser classifies each accepted byte in the cycle it arrives and writes
// the result into a two-entry queue that drives o_out, so a result is
// offered the cycle after its byte is accepted and one byte per cycle is
// sustained while the receiver takes results every cycle. When the receiver
// stalls, the queue fills and i_in.ready falls after two pending results;
// it rises again the cycle after a result is taken. Six 8-bit registers are
// written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must do so
// only while the block is idle, unenforced by the block; other indexes
// are ignored. Synchronous reset restores the register defaults, empties
// the queue, waits for a record header and clears the sticky error. After
// an error every byte is passed through with the ignored route until reset.
`timescale 1ns / 1ps

module fastcgi_record_deframer
    import frd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    frd_byte_if.sink              i_in,
    frd_rec_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic push;
    logic space;
    t_res push_res;
    t_res head_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version      <= 8'd1;
            r_cfg.max_record_type       <= 8'd11;
            r_cfg.stdout_type_code      <= 8'd6;
            r_cfg.stderr_type_code      <= 8'd7;
            r_cfg.end_request_type_code <= 8'd3;
            r_cfg.complete_status_code  <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_data;
                CFG_MAX_RECORD_TYPE:  r_cfg.max_record_type <= i_cfg_data;
                CFG_STDOUT_TYPE:      r_cfg.stdout_type_code <= i_cfg_data;
                CFG_STDERR_TYPE:      r_cfg.stderr_type_code <= i_cfg_data;
                CFG_END_REQUEST_TYPE: r_cfg.end_request_type_code <= i_cfg_data;
                CFG_COMPLETE_STATUS:  r_cfg.complete_status_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = space;

    frd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .i_byte  (i_in.stream_byte),
        .i_space (space),
        .o_push  (push),
        .o_res   (push_res)
    );

    frd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (head_res)
    );

    assign o_out.payload_byte      = head_res.payload_byte;
    assign o_out.route             = head_res.route;
    assign o_out.record_type       = head_res.record_type;
    assign o_out.content_remaining = head_res.content_remaining;
    assign o_out.record_done       = head_res.record_done;
    assign o_out.exit_status       = head_res.exit_status;
    assign o_out.exit_valid        = head_res.exit_valid;
    assign o_out.error_code        = head_res.error_code;

endmodule
